### src/dpwp_pkg.sv
// shared types, constants and register codes for the depth pixel to world point core
package dpwp_pkg;

  localparam int COORD_BITS = 12;
  localparam int PIX_W      = 12;
  localparam logic [PIX_W-1:0] PIX_MASK =
    (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

  // camera axis datapath widths
  localparam int DU_W       = 18;
  localparam int DD_W       = 35;
  localparam int PP_W       = 48;
  localparam int INV_HALF   = 12;
  localparam int P_W        = PP_W + INV_HALF;
  localparam int CAM_SHIFT  = 20;
  localparam int CAM_W      = 38;
  localparam logic [P_W-1:0] CAM_ROUND = P_W'(1) << (CAM_SHIFT - 1);

  // world axis datapath widths
  localparam int PROD_W      = 54;
  localparam int ACC_W       = 56;
  localparam int ORIGIN_SHIFT = 22;
  localparam int WORLD_SHIFT = 14;
  localparam int SHIFTED_W   = ACC_W - WORLD_SHIFT;
  localparam int WORLD_W     = 32;
  localparam logic [ACC_W-1:0] WORLD_ROUND = ACC_W'(1) << (WORLD_SHIFT - 1);

  localparam int NUM_STAGES = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_COL      = 3'd0,
    REG_CENTER_ROW      = 3'd1,
    REG_INV_FOCAL_COL   = 3'd2,
    REG_INV_FOCAL_ROW   = 3'd3,
    REG_TRANSFORM_ROW_X = 3'd4,
    REG_TRANSFORM_ROW_Y = 3'd5,
    REG_TRANSFORM_ROW_Z = 3'd6
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] TRANSFORM_X_RESET = 64'd16384;
  localparam logic [CFG_DATA_W-1:0] TRANSFORM_Y_RESET = 64'd1073741824;
  localparam logic [CFG_DATA_W-1:0] TRANSFORM_Z_RESET = 64'd70368744177664;

  typedef struct packed {
    logic [15:0] center_col;
    logic [15:0] center_row;
    logic [23:0] inv_focal_col;
    logic [23:0] inv_focal_row;
    logic [CFG_DATA_W-1:0] transform_row_x;
    logic [CFG_DATA_W-1:0] transform_row_y;
    logic [CFG_DATA_W-1:0] transform_row_z;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    logic [15:0]      depth_mm;
    logic [7:0]       red_in;
    logic [7:0]       green_in;
    logic [7:0]       blue_in;
  } pixel_word_t;

  typedef struct packed {
    logic                      point_valid;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic [7:0]                red_out;
    logic [7:0]                green_out;
    logic [7:0]                blue_out;
  } point_word_t;

  // load enables of three consecutive pipeline stages
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic load_c;
  } stage_en_t;

  // values that ride alongside the arithmetic
  typedef struct packed {
    logic        nonzero;
    logic [15:0] depth;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } side_t;

endpackage

### src/dpwp_cfg_regs.sv
// configuration register bank with write channel
module dpwp_cfg_regs
  import dpwp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.center_col      <= '0;
      regs.center_row      <= '0;
      regs.inv_focal_col   <= '0;
      regs.inv_focal_row   <= '0;
      regs.transform_row_x <= TRANSFORM_X_RESET;
      regs.transform_row_y <= TRANSFORM_Y_RESET;
      regs.transform_row_z <= TRANSFORM_Z_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_COL:      regs.center_col      <= cfg_data[15:0];
        REG_CENTER_ROW:      regs.center_row      <= cfg_data[15:0];
        REG_INV_FOCAL_COL:   regs.inv_focal_col   <= cfg_data[23:0];
        REG_INV_FOCAL_ROW:   regs.inv_focal_row   <= cfg_data[23:0];
        REG_TRANSFORM_ROW_X: regs.transform_row_x <= cfg_data;
        REG_TRANSFORM_ROW_Y: regs.transform_row_y <= cfg_data;
        REG_TRANSFORM_ROW_Z: regs.transform_row_z <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/dpwp_cam_axis.sv
// three-stage back-projection of one pixel axis, gives the negated camera coordinate in Q.8
module dpwp_cam_axis
  import dpwp_pkg::*;
(
  input  logic                    clk,
  input  stage_en_t               en,
  input  logic [PIX_W-1:0]        pix,
  input  logic [15:0]             center,
  input  logic [23:0]             inv_focal,
  input  logic [15:0]             depth,
  output logic signed [CAM_W-1:0] neg_cam
);

  logic [PIX_W-1:0]        pix_masked;
  logic signed [DU_W-1:0]  du;
  logic signed [DD_W-1:0]  dd;
  logic signed [PP_W-1:0]  prod_lo;
  logic signed [PP_W-1:0]  prod_hi;
  logic signed [P_W-1:0]   p_sum;
  logic signed [CAM_W-1:0] cam_val;

  assign pix_masked = pix & PIX_MASK;
  // Q.4 offset from the principal point
  assign du = $signed({2'b00, pix_masked, 4'b0000}) - $signed({2'b00, center});

  // full Q.28 product, then round half up to Q.8
  assign p_sum   = (P_W'(prod_hi) <<< INV_HALF) + P_W'(prod_lo) + $signed(CAM_ROUND);
  assign cam_val = $signed(p_sum[CAM_W+CAM_SHIFT-1:CAM_SHIFT]);

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      dd <= DD_W'(du) * DD_W'($signed({1'b0, depth}));
    end
    if (en.load_b) begin
      prod_lo <= PP_W'(dd) * PP_W'($signed({1'b0, inv_focal[INV_HALF-1:0]}));
      prod_hi <= PP_W'(dd) * PP_W'($signed({1'b0, inv_focal[2*INV_HALF-1:INV_HALF]}));
    end
    if (en.load_c) begin
      neg_cam <= -cam_val;
    end
  end

endmodule

### src/dpwp_world_axis.sv
// three-stage basis row product, origin add, rounding and saturation for one world axis
module dpwp_world_axis
  import dpwp_pkg::*;
(
  input  logic                      clk,
  input  stage_en_t                 en,
  input  logic [CFG_DATA_W-1:0]     row,
  input  logic [15:0]               depth,
  input  logic signed [CAM_W-1:0]   neg_x,
  input  logic signed [CAM_W-1:0]   neg_y,
  output logic signed [WORLD_W-1:0] world
);

  logic signed [15:0]          b0;
  logic signed [15:0]          b1;
  logic signed [15:0]          b2;
  logic signed [15:0]          origin;
  logic signed [PROD_W-1:0]    prod_z;
  logic signed [PROD_W-1:0]    prod_nx;
  logic signed [PROD_W-1:0]    prod_ny;
  logic signed [ACC_W-1:0]     acc;
  logic signed [SHIFTED_W-1:0] shifted;
  logic signed [WORLD_W-1:0]   sat;

  assign b0     = $signed(row[15:0]);
  assign b1     = $signed(row[31:16]);
  assign b2     = $signed(row[47:32]);
  assign origin = $signed(row[63:48]);

  // floor shift of the rounded Q.22 sum down to Q.8
  assign shifted = $signed(acc[ACC_W-1:WORLD_SHIFT]);

  always_comb begin
    if (shifted[SHIFTED_W-1:WORLD_W-1] == {(SHIFTED_W-WORLD_W+1){shifted[WORLD_W-1]}}) begin
      sat = shifted[WORLD_W-1:0];
    end else if (shifted[SHIFTED_W-1]) begin
      sat = {1'b1, {(WORLD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(WORLD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      // camera z is the depth in Q.8
      prod_z  <= PROD_W'($signed({1'b0, depth, 8'h00})) * PROD_W'(b0);
      prod_nx <= PROD_W'(neg_x) * PROD_W'(b1);
      prod_ny <= PROD_W'(neg_y) * PROD_W'(b2);
    end
    if (en.load_b) begin
      acc <= ACC_W'(prod_z) + ACC_W'(prod_nx) + ACC_W'(prod_ny)
           + (ACC_W'(origin) <<< ORIGIN_SHIFT) + $signed(WORLD_ROUND);
    end
    if (en.load_c) begin
      world <= sat;
    end
  end

endmodule

### src/depth_pixel_to_world_point_core.sv
// top level: depth pixel back-projection and rigid transform pipeline
// Throughput is one depth pixel word in and one world point word out per cycle while
// out_ready stays high, set by the six-stage arithmetic pipeline
// (three stages of pinhole back-projection, three of basis product, sum and
// saturation). Each stage holds when the one after it is full and stalled, so empty
// stages still fill while a finished word waits at the output. Configuration writes
// take effect at once and are meant for when no pixel is in flight. A pixel of zero
// depth gives a word with point_valid low and all other fields zero.
module depth_pixel_to_world_point_core
  import dpwp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pixel_word_t           in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output point_word_t           out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                      cfg;
  logic [NUM_STAGES-1:0]     stage_valid;
  logic [NUM_STAGES:0]       load;
  side_t                     side [NUM_STAGES];
  side_t                     side_in;
  stage_en_t                 cam_en;
  stage_en_t                 world_en;
  logic signed [CAM_W-1:0]   neg_x;
  logic signed [CAM_W-1:0]   neg_y;
  logic signed [WORLD_W-1:0] wx;
  logic signed [WORLD_W-1:0] wy;
  logic signed [WORLD_W-1:0] wz;

  dpwp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a stage loads when empty or when the next one loads
  always_comb begin
    load[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      load[i] = !stage_valid[i] || load[i+1];
    end
  end

  assign in_ready = load[0];
  assign cam_en   = '{load_a: load[0], load_b: load[1], load_c: load[2]};
  assign world_en = '{load_a: load[3], load_b: load[4], load_c: load[5]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (load[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (load[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign side_in = '{nonzero: (in_data.depth_mm != 16'd0),
                     depth:   in_data.depth_mm,
                     red:     in_data.red_in,
                     green:   in_data.green_in,
                     blue:    in_data.blue_in};

  always_ff @(posedge clk) begin
    if (load[0]) begin
      side[0] <= side_in;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (load[i]) begin
        side[i] <= side[i-1];
      end
    end
  end

  dpwp_cam_axis u_cam_col (
    .clk       (clk),
    .en        (cam_en),
    .pix       (in_data.pixel_col),
    .center    (cfg.center_col),
    .inv_focal (cfg.inv_focal_col),
    .depth     (in_data.depth_mm),
    .neg_cam   (neg_x)
  );

  dpwp_cam_axis u_cam_row (
    .clk       (clk),
    .en        (cam_en),
    .pix       (in_data.pixel_row),
    .center    (cfg.center_row),
    .inv_focal (cfg.inv_focal_row),
    .depth     (in_data.depth_mm),
    .neg_cam   (neg_y)
  );

  dpwp_world_axis u_world_x (
    .clk   (clk),
    .en    (world_en),
    .row   (cfg.transform_row_x),
    .depth (side[2].depth),
    .neg_x (neg_x),
    .neg_y (neg_y),
    .world (wx)
  );

  dpwp_world_axis u_world_y (
    .clk   (clk),
    .en    (world_en),
    .row   (cfg.transform_row_y),
    .depth (side[2].depth),
    .neg_x (neg_x),
    .neg_y (neg_y),
    .world (wy)
  );

  dpwp_world_axis u_world_z (
    .clk   (clk),
    .en    (world_en),
    .row   (cfg.transform_row_z),
    .depth (side[2].depth),
    .neg_x (neg_x),
    .neg_y (neg_y),
    .world (wz)
  );

  assign out_valid = stage_valid[NUM_STAGES-1];

  // zero depth clears the whole word
  always_comb begin
    if (side[NUM_STAGES-1].nonzero) begin
      out_data = '{point_valid: 1'b1,
                   world_x:     wx,
                   world_y:     wy,
                   world_z:     wz,
                   red_out:     side[NUM_STAGES-1].red,
                   green_out:   side[NUM_STAGES-1].green,
                   blue_out:    side[NUM_STAGES-1].blue};
    end else begin
      out_data = '0;
    end
  end

endmodule

### tb/tb_depth_pixel_to_world_point_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the depth pixel to world point core
module tb_depth_pixel_to_world_point_core;
  import dpwp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam longint Q8_MAX = 64'sd2147483647;
  localparam longint Q8_MIN = -64'sd2147483648;
  localparam int REPORT_CAP = 40;
  localparam int DRAIN_CYCLES = 4 * NUM_STAGES;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pixel_word_t           in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  point_word_t           out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t        cam;
  pixel_word_t pixel_backlog[$];
  point_word_t point_expect[$];
  int          pixels_offered = 0;
  int          pixels_taken = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          recv_hold_cycles = 0;
  int          mismatches = 0;

  depth_pixel_to_world_point_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // camera-frame coordinate in Q.8 mm, round half up
  function automatic longint cam_axis_q8(logic [PIX_W-1:0] pix, logic [15:0] centre,
                                         logic [23:0] inv, longint d);
    longint du;
    du = longint'({pix & PIX_MASK, 4'b0000}) - longint'(centre);
    return (du * d * longint'(inv) + (longint'(1) <<< (CAM_SHIFT - 1))) >>> CAM_SHIFT;
  endfunction

  function automatic logic signed [WORLD_W-1:0] world_q8(logic [CFG_DATA_W-1:0] row,
                                                         longint nx, longint ny, longint nz);
    shortint b0, b1, b2, origin;
    longint  acc;
    b0 = row[15:0];
    b1 = row[31:16];
    b2 = row[47:32];
    origin = row[63:48];
    acc = nx * b0 + ny * b1 + nz * b2 + (longint'(origin) <<< ORIGIN_SHIFT);
    acc = (acc + (longint'(1) <<< (WORLD_SHIFT - 1))) >>> WORLD_SHIFT;
    if (acc > Q8_MAX) acc = Q8_MAX;
    else if (acc < Q8_MIN) acc = Q8_MIN;
    return acc[WORLD_W-1:0];
  endfunction

  function automatic point_word_t project_pixel(pixel_word_t px);
    point_word_t pt;
    longint      d, x, y;
    pt = '0;
    d = longint'(px.depth_mm);
    if (d != 0) begin
      x = cam_axis_q8(px.pixel_col, cam.center_col, cam.inv_focal_col, d);
      y = cam_axis_q8(px.pixel_row, cam.center_row, cam.inv_focal_row, d);
      // camera axes reordered to (z, -x, -y)
      pt.point_valid = 1'b1;
      pt.world_x = world_q8(cam.transform_row_x, d <<< 8, -x, -y);
      pt.world_y = world_q8(cam.transform_row_y, d <<< 8, -x, -y);
      pt.world_z = world_q8(cam.transform_row_z, d <<< 8, -x, -y);
      pt.red_out = px.red_in;
      pt.green_out = px.green_in;
      pt.blue_out = px.blue_in;
    end
    return pt;
  endfunction

  function automatic pixel_word_t make_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                                             logic [15:0] depth, logic [7:0] r,
                                             logic [7:0] g, logic [7:0] b);
    return {col, row, depth, r, g, b};
  endfunction

  function automatic pixel_word_t random_pixel();
    pixel_word_t px;
    px = pixel_word_t'({$urandom, $urandom});
    if ($urandom_range(9) == 0) px.depth_mm = '0;
    else if ($urandom_range(9) == 0) px.depth_mm = 16'($urandom_range(1, 8));
    return px;
  endfunction

  // basis entries within +-1.0 and an origin within +-2 m
  function automatic logic [CFG_DATA_W-1:0] random_row();
    return {16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 32768) - 16384),
            16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384)};
  endfunction

  function automatic cfg_t random_camera(bit wild);
    cfg_t c;
    if (wild) begin
      c.center_col = 16'($urandom);
      c.center_row = 16'($urandom);
      c.inv_focal_col = 24'($urandom);
      c.inv_focal_row = 24'($urandom);
      c.transform_row_x = {$urandom, $urandom};
      c.transform_row_y = {$urandom, $urandom};
      c.transform_row_z = {$urandom, $urandom};
    end else begin
      c.center_col = 16'($urandom_range(0, 65520));
      c.center_row = 16'($urandom_range(0, 65520));
      c.inv_focal_col = 24'($urandom_range(8000, 170000));
      c.inv_focal_row = 24'($urandom_range(8000, 170000));
      c.transform_row_x = random_row();
      c.transform_row_y = random_row();
      c.transform_row_z = random_row();
    end
    return c;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("%0t ns: %s", $time, what);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTER_COL:      cam.center_col = val[15:0];
      REG_CENTER_ROW:      cam.center_row = val[15:0];
      REG_INV_FOCAL_COL:   cam.inv_focal_col = val[23:0];
      REG_INV_FOCAL_ROW:   cam.inv_focal_row = val[23:0];
      REG_TRANSFORM_ROW_X: cam.transform_row_x = val;
      REG_TRANSFORM_ROW_Y: cam.transform_row_y = val;
      REG_TRANSFORM_ROW_Z: cam.transform_row_z = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_camera(cfg_t c);
    write_reg(REG_CENTER_COL, 64'(c.center_col));
    write_reg(REG_CENTER_ROW, 64'(c.center_row));
    write_reg(REG_INV_FOCAL_COL, 64'(c.inv_focal_col));
    write_reg(REG_INV_FOCAL_ROW, 64'(c.inv_focal_row));
    write_reg(REG_TRANSFORM_ROW_X, c.transform_row_x);
    write_reg(REG_TRANSFORM_ROW_Y, c.transform_row_y);
    write_reg(REG_TRANSFORM_ROW_Z, c.transform_row_z);
    // unmapped index, must leave every register alone
    write_reg(REG_NONE, {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || pixels_taken != pixels_offered ||
           point_expect.size() != 0);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int hold, int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) pixel_backlog.push_back(random_pixel());
    @(posedge clk);
    recv_hold_cycles = hold;
    wait_drained();
  endtask

  // sender: words leave the backlog at the falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      point_expect.push_back(project_pixel(in_data));
      pixels_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pixels_taken == pixels_offered) begin
      if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pixel_backlog.pop_front();
        pixels_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: a long hold-off takes priority over random stalls
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      out_ready <= 1'b0;
      recv_hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    point_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (point_expect.size() == 0) begin
        note_mismatch("point word with nothing expected");
      end else begin
        want = point_expect.pop_front();
        if (out_data.point_valid !== want.point_valid)
          note_mismatch($sformatf("point_valid got %0b want %0b",
                                  out_data.point_valid, want.point_valid));
        if (out_data.world_x !== want.world_x)
          note_mismatch($sformatf("world_x got %0d want %0d", out_data.world_x, want.world_x));
        if (out_data.world_y !== want.world_y)
          note_mismatch($sformatf("world_y got %0d want %0d", out_data.world_y, want.world_y));
        if (out_data.world_z !== want.world_z)
          note_mismatch($sformatf("world_z got %0d want %0d", out_data.world_z, want.world_z));
        if (out_data.red_out !== want.red_out)
          note_mismatch($sformatf("red_out got %0h want %0h", out_data.red_out, want.red_out));
        if (out_data.green_out !== want.green_out)
          note_mismatch($sformatf("green_out got %0h want %0h",
                                  out_data.green_out, want.green_out));
        if (out_data.blue_out !== want.blue_out)
          note_mismatch($sformatf("blue_out got %0h want %0h",
                                  out_data.blue_out, want.blue_out));
      end
    end
  end

  initial begin
    cfg_t corner_cam;
    cfg_t floor_cam;
    cam = '0;
    cam.transform_row_x = TRANSFORM_X_RESET;
    cam.transform_row_y = TRANSFORM_Y_RESET;
    cam.transform_row_z = TRANSFORM_Z_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers as they come out of reset
    pixel_backlog.push_back(make_pixel(12'hFFF, 12'hFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF));
    pixel_backlog.push_back(make_pixel(12'h000, 12'h000, 16'h0001, 8'h00, 8'h00, 8'h00));
    pixel_backlog.push_back(make_pixel(12'hFFF, 12'h000, 16'hFFFF, 8'hFF, 8'h00, 8'hFF));
    pixel_backlog.push_back(make_pixel(12'hAAA, 12'h555, 16'h8000, 8'hAA, 8'h55, 8'h0F));
    pixel_backlog.push_back(make_pixel(12'h555, 12'hAAA, 16'h7FFF, 8'h55, 8'hAA, 8'hF0));
    wait_drained();

    // full-scale focal and basis terms, drives every axis into saturation
    corner_cam.center_col = 16'h0000;
    corner_cam.center_row = 16'hFFFF;
    corner_cam.inv_focal_col = 24'hFFFFFF;
    corner_cam.inv_focal_row = 24'hFFFFFF;
    corner_cam.transform_row_x = {4{16'h7FFF}};
    corner_cam.transform_row_y = {4{16'h8000}};
    corner_cam.transform_row_z = {16'h0000, 16'h8000, 16'h7FFF, 16'h0000};
    program_camera(corner_cam);
    pixel_backlog.push_back(make_pixel(12'h000, 12'h000, 16'hFFFF, 8'h12, 8'h34, 8'h56));
    pixel_backlog.push_back(make_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    pixel_backlog.push_back(make_pixel(12'hFFF, 12'h000, 16'hFFFF, 8'h00, 8'hFF, 8'h00));
    pixel_backlog.push_back(make_pixel(12'h000, 12'hFFF, 16'h0001, 8'h80, 8'h01, 8'h7F));
    pixel_backlog.push_back(make_pixel(12'h800, 12'h800, 16'h0000, 8'hC3, 8'h3C, 8'h99));
    pixel_backlog.push_back(make_pixel(12'h001, 12'h001, 16'h0001, 8'h01, 8'h02, 8'h04));
    pixel_backlog.push_back(make_pixel(12'hFFF, 12'hFFF, 16'h0100, 8'hFE, 8'hFD, 8'hFB));
    wait_drained();

    // back-to-back words, with a long output hold-off to fill the pipe
    program_camera(random_camera(1'b0));
    run_phase(0, 0, 400, 400);

    program_camera(random_camera(1'b1));
    run_phase(61, 0, 0, 400);

    program_camera(random_camera(1'b0));
    run_phase(0, 61, 0, 400);

    floor_cam = random_camera(1'b0);
    floor_cam.center_col = 16'hFFFF;
    floor_cam.center_row = 16'hFFFF;
    floor_cam.inv_focal_col = 24'h000000;
    floor_cam.inv_focal_row = 24'hFFFFFF;
    floor_cam.transform_row_x[63:48] = 16'h8000;
    floor_cam.transform_row_y[63:48] = 16'h8000;
    floor_cam.transform_row_z[63:48] = 16'h8000;
    program_camera(floor_cam);
    // sender stops until every word is back, then carries on
    run_phase(23, 23, 0, 200);
    run_phase(23, 23, 0, 200);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
